// ----- rtl/dte_pkg.sv -----
// Shared types and constants for the dictionary token expander.
`timescale 1ns / 1ps
`default_nettype none
package dte_pkg;

  localparam int TOKEN_W   = 16;
  localparam int INDEX_W   = 17;
  localparam int OFFSET_W  = 22;
  localparam int ADDR_W    = 21;
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 4;
  localparam int REMAIN_W  = 10;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 72;

  localparam logic [ACTION_W-1:0] ACT_WR_BYTE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_OFFSET = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EXPAND    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_OFFA  = 5'b00010,
    S_OFFB  = 5'b00100,
    S_LEN   = 5'b01000,
    S_FETCH = 5'b10000
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } dict_wr_t;

  typedef struct packed {
    logic                en;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] value;
  } off_wr_t;

endpackage
`default_nettype wire

// ----- rtl/dte_dict_ram.sv -----
// Dictionary byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dte_dict_ram import dte_pkg::*; #(
  parameter int DICT_BYTES = 2097152
) (
  input  wire logic                clk,
  input  wire dict_wr_t            wr,
  input  wire logic                rd_en,
  input  wire logic [OFFSET_W-1:0] rd_pos,
  output logic      [BYTE_W-1:0]   rd_byte
);

  localparam int AW = (DICT_BYTES > 1) ? $clog2(DICT_BYTES) : 1;

  logic [BYTE_W-1:0] mem [DICT_BYTES];
  logic [31:0]       wr_ext;
  logic [31:0]       rd_ext;
  logic [BYTE_W-1:0] rd_q;
  logic              rd_ok;

  assign wr_ext = 32'(wr.addr);
  assign rd_ext = 32'(rd_pos);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_ext < 32'(DICT_BYTES))) begin
      mem[wr_ext[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_ext[AW-1:0]];
      rd_ok <= rd_ext < 32'(DICT_BYTES);
    end
  end

  // positions past the store read as zero
  assign rd_byte = rd_ok ? rd_q : '0;

endmodule
`default_nettype wire

// ----- rtl/dte_offset_ram.sv -----
// Token start offset table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dte_offset_ram import dte_pkg::*; #(
  parameter int TOKEN_COUNT = 65536
) (
  input  wire logic                clk,
  input  wire off_wr_t             wr,
  input  wire logic                rd_en,
  input  wire logic [INDEX_W-1:0]  rd_index,
  output logic      [OFFSET_W-1:0] rd_value
);

  localparam int DEPTH = TOKEN_COUNT + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [OFFSET_W-1:0] mem [DEPTH];
  logic [31:0]         wr_ext;
  logic [31:0]         rd_ext;

  assign wr_ext = 32'(wr.index);
  assign rd_ext = 32'(rd_index);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_ext <= 32'(TOKEN_COUNT))) begin
      mem[wr_ext[AW-1:0]] <= wr.value;
    end
    if (rd_en) begin
      rd_value <= mem[rd_ext[AW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dictionary_token_expander_top.sv -----
// Top level: request decode, expand sequencer, byte assembly and output register.
// Write request: acknowledged in the cycle after it is taken.
// Expand request: offset lookup and length in S_OFFA, S_OFFB and S_LEN, then beats of up to BEAT_BYTES bytes,
// read by the single dictionary read port at one byte per cycle; a beat waits for a free output register.
// One request at a time; the next is taken once the sequencer is idle and the output register is free or draining.
// rst clears the sequencer and output valid; both stores hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none
module dictionary_token_expander_top import dte_pkg::*; #(
  parameter int TOKEN_COUNT     = 65536,
  parameter int DICT_BYTES      = 2097152,
  parameter int MAX_ENTRY_BYTES = 512,
  parameter int BEAT_BYTES      = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // token, offset_index, offset_value, byte_address, byte_value, zero fill
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // action
  input  wire logic [ACTION_W-1:0]  s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // data_bytes, byte_count, zero fill
  output logic      [M_TDATA_W-1:0] m_tdata,
  output logic                      m_tlast,
  // status
  output logic      [STATUS_W-1:0]  m_tuser
);

  localparam int CW = $clog2(BEAT_BYTES + 1);

  logic [TOKEN_W-1:0]  in_token;
  logic [INDEX_W-1:0]  in_index;
  logic [OFFSET_W-1:0] in_offset;
  logic [ADDR_W-1:0]   in_addr;
  logic [BYTE_W-1:0]   in_byte;

  assign in_token  = s_tdata[15:0];
  assign in_index  = s_tdata[32:16];
  assign in_offset = s_tdata[54:33];
  assign in_addr   = s_tdata[75:55];
  assign in_byte   = s_tdata[83:76];

  state_t state, state_next;

  logic                  out_valid, out_valid_next;
  logic [DATA_W-1:0]     out_data, out_data_next;
  logic [COUNT_W-1:0]    out_count, out_count_next;
  logic                  out_last, out_last_next;
  logic [STATUS_W-1:0]   out_status, out_status_next;

  logic [INDEX_W-1:0]    tok1, tok1_next;
  logic                  tok_ok, tok_ok_next;
  logic [OFFSET_W-1:0]   start_pos, start_pos_next;
  logic [OFFSET_W-1:0]   end_pos, end_pos_next;
  logic [OFFSET_W-1:0]   cursor, cursor_next;
  logic [REMAIN_W-1:0]   remaining, remaining_next;
  logic [STATUS_W-1:0]   status_r, status_r_next;
  logic [CW-1:0]         issue_cnt, issue_cnt_next;
  logic [CW-1:0]         recv_cnt, recv_cnt_next;
  logic                  rd_pending, rd_pending_next;
  logic [BEAT_BYTES-1:0][BYTE_W-1:0] beat, beat_next;

  logic                  accept;
  logic                  out_free;
  logic [CW-1:0]         beat_n;
  logic                  order_err;
  logic [OFFSET_W-1:0]   diff;
  logic                  trunc;
  logic [REMAIN_W-1:0]   len;

  dict_wr_t              dict_wr;
  logic                  dict_rd_en;
  logic [BYTE_W-1:0]     dict_byte;
  off_wr_t               off_wr;
  logic                  off_rd_en;
  logic [INDEX_W-1:0]    off_rd_index;
  logic [OFFSET_W-1:0]   off_value;

  dte_dict_ram #(.DICT_BYTES(DICT_BYTES)) u_dict (
    .clk     (clk),
    .wr      (dict_wr),
    .rd_en   (dict_rd_en),
    .rd_pos  (cursor),
    .rd_byte (dict_byte)
  );

  dte_offset_ram #(.TOKEN_COUNT(TOKEN_COUNT)) u_offset (
    .clk      (clk),
    .wr       (off_wr),
    .rd_en    (off_rd_en),
    .rd_index (off_rd_index),
    .rd_value (off_value)
  );

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign beat_n = (remaining < REMAIN_W'(BEAT_BYTES)) ? CW'(remaining) : CW'(BEAT_BYTES);

  assign order_err = end_pos < start_pos;
  assign diff      = end_pos - start_pos;
  assign trunc     = diff > OFFSET_W'(MAX_ENTRY_BYTES);
  assign len       = trunc ? REMAIN_W'(MAX_ENTRY_BYTES) : diff[REMAIN_W-1:0];

  assign dict_wr.en   = accept && (s_tuser == ACT_WR_BYTE);
  assign dict_wr.addr = in_addr;
  assign dict_wr.data = in_byte;
  assign off_wr.en    = accept && (s_tuser == ACT_WR_OFFSET);
  assign off_wr.index = in_index;
  assign off_wr.value = in_offset;

  assign off_rd_en    = (accept && (s_tuser == ACT_EXPAND)) || (state == S_OFFA);
  assign off_rd_index = (state == S_OFFA) ? tok1 : {1'b0, in_token};
  assign dict_rd_en   = (state == S_FETCH) && (issue_cnt != beat_n);

  always_comb begin
    state_next      = state;
    out_valid_next  = out_valid && !m_tready;
    out_data_next   = out_data;
    out_count_next  = out_count;
    out_last_next   = out_last;
    out_status_next = out_status;
    tok1_next       = tok1;
    tok_ok_next     = tok_ok;
    start_pos_next  = start_pos;
    end_pos_next    = end_pos;
    cursor_next     = cursor;
    remaining_next  = remaining;
    status_r_next   = status_r;
    issue_cnt_next  = issue_cnt;
    recv_cnt_next   = recv_cnt;
    rd_pending_next = dict_rd_en;
    beat_next       = beat;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == ACT_EXPAND) begin
            tok1_next   = {1'b0, in_token} + INDEX_W'(1);
            tok_ok_next = 32'(in_token) < 32'(TOKEN_COUNT);
            state_next  = S_OFFA;
          end else begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_count_next  = '0;
            out_last_next   = 1'b1;
            out_status_next = ST_OK;
          end
        end
      end
      S_OFFA: begin
        start_pos_next = tok_ok ? off_value : '0;
        state_next     = S_OFFB;
      end
      S_OFFB: begin
        end_pos_next = tok_ok ? off_value : '0;
        state_next   = S_LEN;
      end
      S_LEN: begin
        beat_next      = '0;
        issue_cnt_next = '0;
        recv_cnt_next  = '0;
        cursor_next    = start_pos;
        remaining_next = len;
        status_r_next  = trunc ? ST_TRUNC : ST_OK;
        if (!order_err && (len != '0)) begin
          state_next = S_FETCH;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_data_next   = '0;
          out_count_next  = '0;
          out_last_next   = 1'b1;
          out_status_next = order_err ? ST_ORDER : ST_OK;
          state_next      = S_IDLE;
        end
      end
      S_FETCH: begin
        if (dict_rd_en) begin
          cursor_next    = cursor + OFFSET_W'(1);
          issue_cnt_next = issue_cnt + CW'(1);
        end
        if (rd_pending) begin
          for (int i = 0; i < BEAT_BYTES; i++) begin
            if (recv_cnt == CW'(i)) begin
              beat_next[i] = dict_byte;
            end
          end
          recv_cnt_next = recv_cnt + CW'(1);
        end
        if ((recv_cnt == beat_n) && !rd_pending && out_free) begin
          out_valid_next  = 1'b1;
          out_data_next   = DATA_W'(beat);
          out_count_next  = COUNT_W'(beat_n);
          out_last_next   = remaining == REMAIN_W'(beat_n);
          out_status_next = status_r;
          remaining_next  = remaining - REMAIN_W'(beat_n);
          issue_cnt_next  = '0;
          recv_cnt_next   = '0;
          beat_next       = '0;
          if (remaining == REMAIN_W'(beat_n)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      issue_cnt  <= '0;
      recv_cnt   <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      issue_cnt  <= issue_cnt_next;
      recv_cnt   <= recv_cnt_next;
      rd_pending <= rd_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data   <= out_data_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
    tok1       <= tok1_next;
    tok_ok     <= tok_ok_next;
    start_pos  <= start_pos_next;
    end_pos    <= end_pos_next;
    cursor     <= cursor_next;
    remaining  <= remaining_next;
    status_r   <= status_r_next;
    beat       <= beat_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, out_count, out_data};
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] <= 4'(BEAT_BYTES)))
    else $error("byte count above beat width");

  a_full_beats: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[67:64] == 4'(BEAT_BYTES)))
    else $error("non-final beat not full");

  a_order_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_ORDER)) |-> (m_tlast && (m_tdata[67:64] == '0)))
    else $error("order error result carries data");

  a_recv_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (recv_cnt <= issue_cnt))
    else $error("byte received without a read");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(dict_wr.en && dict_rd_en))
    else $error("dictionary read during write");

endmodule
`default_nettype wire

// ----- bench/tb_dictionary_token_expander_top.sv -----
// Self-checking stream testbench for the dictionary token expander.
`timescale 1ns / 1ps
module tb_dictionary_token_expander_top;
  import dte_pkg::*;

  localparam int TOKEN_COUNT     = 65536;
  localparam int DICT_BYTES      = 2097152;
  localparam int MAX_ENTRY_BYTES = 512;
  localparam int BEAT_BYTES      = 8;

  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  localparam int PRELOAD    = 516;
  localparam int RAND_ITEMS = 180;
  localparam int IDLE_PCT   = 37;
  localparam int SEND_CALM_LO = 580;
  localparam int SEND_CALM_HI = 640;
  localparam int RECV_CALM_LO = 760;
  localparam int RECV_CALM_HI = 860;
  localparam int HOLD_AT    = 700;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN      = 20;
  localparam int LIMIT      = 3000000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TOKEN_W-1:0]  token;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] value;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic                last;
    logic [STATUS_W-1:0] status;
  } expanded_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [ACTION_W-1:0]  s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic [STATUS_W-1:0]  m_tuser;

  request_t       pending_requests[$];
  request_t       in_flight;
  expanded_beat_t expected_beats[$];
  expanded_beat_t want, got;

  // store images for prediction
  logic [BYTE_W-1:0]   dict_image[int unsigned];
  logic [OFFSET_W-1:0] offset_image[int unsigned];
  // what generation has written so far, to keep expands on written entries
  bit                  written_byte[int unsigned];
  logic [OFFSET_W-1:0] written_offset[int unsigned];
  int unsigned         known_tokens[$];

  int n_taken = 0;
  int n_done = 0;
  int n_fail = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int cycle_count = 0;

  dictionary_token_expander_top #(
    .TOKEN_COUNT(TOKEN_COUNT),
    .DICT_BYTES(DICT_BYTES),
    .MAX_ENTRY_BYTES(MAX_ENTRY_BYTES),
    .BEAT_BYTES(BEAT_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic expanded_beat_t ack_beat();
    expanded_beat_t b;
    b.data = '0;
    b.count = '0;
    b.last = 1'b1;
    b.status = ST_OK;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] dict_byte(input int unsigned pos);
    if (pos < DICT_BYTES && dict_image.exists(pos)) return dict_image[pos];
    return '0;
  endfunction

  task automatic expect_beat(input expanded_beat_t b);
    expected_beats = {expected_beats, b};
  endtask

  task automatic enqueue_request(input request_t r);
    pending_requests = {pending_requests, r};
  endtask

  task automatic predict_expansion(input request_t r);
    expanded_beat_t b;
    logic [OFFSET_W-1:0] first, stop, cursor;
    logic [STATUS_W-1:0] st;
    int unsigned span, n;
    case (r.action)
      ACT_WR_BYTE: begin
        dict_image[r.addr] = r.data;
        expect_beat(ack_beat());
      end
      ACT_WR_OFFSET: begin
        if (r.index <= TOKEN_COUNT) offset_image[r.index] = r.value;
        expect_beat(ack_beat());
      end
      ACT_EXPAND: begin
        first = '0;
        stop = '0;
        if (r.token < TOKEN_COUNT) begin
          if (offset_image.exists(r.token)) first = offset_image[r.token];
          if (offset_image.exists(r.token + 1)) stop = offset_image[r.token + 1];
        end
        if (stop < first) begin
          b = ack_beat();
          b.status = ST_ORDER;
          expect_beat(b);
        end else begin
          span = 32'(stop) - 32'(first);
          st = ST_OK;
          if (span > MAX_ENTRY_BYTES) begin
            span = MAX_ENTRY_BYTES;
            st = ST_TRUNC;
          end
          if (span == 0) begin
            b = ack_beat();
            b.status = st;
            expect_beat(b);
          end
          cursor = first;
          while (span > 0) begin
            n = (span > BEAT_BYTES) ? BEAT_BYTES : span;
            b.data = '0;
            for (int unsigned i = 0; i < n; i++) begin
              b.data[8*i +: 8] = dict_byte(cursor);
              cursor = cursor + OFFSET_W'(1);
            end
            span = span - n;
            b.count = COUNT_W'(n);
            b.last = (span == 0);
            b.status = st;
            expect_beat(b);
          end
        end
      end
      default: expect_beat(ack_beat());
    endcase
  endtask

  // unused fields carry random in-range values
  function automatic request_t blank_request();
    request_t r;
    r.action = ACT_NOP;
    r.token = TOKEN_W'($urandom_range(0, TOKEN_COUNT - 1));
    r.index = INDEX_W'($urandom_range(0, TOKEN_COUNT));
    r.value = OFFSET_W'($urandom_range(0, DICT_BYTES));
    r.addr = ADDR_W'($urandom_range(0, DICT_BYTES - 1));
    r.data = BYTE_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic queue_byte(input int unsigned addr, input int unsigned val);
    request_t r;
    r = blank_request();
    r.action = ACT_WR_BYTE;
    r.addr = ADDR_W'(addr);
    r.data = BYTE_W'(val);
    written_byte[addr] = 1'b1;
    enqueue_request(r);
  endtask

  task automatic queue_offset(input int unsigned idx, input int unsigned val);
    request_t r;
    r = blank_request();
    r.action = ACT_WR_OFFSET;
    r.index = INDEX_W'(idx);
    r.value = OFFSET_W'(val);
    written_offset[idx] = OFFSET_W'(val);
    enqueue_request(r);
  endtask

  task automatic queue_entry(input int unsigned tok, input int unsigned first,
                             input int unsigned stop);
    if ($urandom_range(0, 1)) begin
      queue_offset(tok, first);
      queue_offset(tok + 1, stop);
    end else begin
      queue_offset(tok + 1, stop);
      queue_offset(tok, first);
    end
  endtask

  task automatic queue_expand(input int unsigned tok);
    request_t r;
    r = blank_request();
    r.action = ACT_EXPAND;
    r.token = TOKEN_W'(tok);
    known_tokens = {known_tokens, tok};
    enqueue_request(r);
  endtask

  task automatic queue_nop();
    enqueue_request(blank_request());
  endtask

  function automatic bit entry_readable(input int unsigned tok);
    int unsigned first, stop, span;
    if (!written_offset.exists(tok) || !written_offset.exists(tok + 1)) return 1'b0;
    first = written_offset[tok];
    stop = written_offset[tok + 1];
    if (stop < first) return 1'b1;
    span = stop - first;
    if (span > MAX_ENTRY_BYTES) span = MAX_ENTRY_BYTES;
    for (int unsigned i = 0; i < span; i++)
      if (first + i < DICT_BYTES && !written_byte.exists(first + i)) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_expansion(in_flight);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 &&
            ((n_taken >= SEND_CALM_LO && n_taken < SEND_CALM_HI) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_flight = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, in_flight.data, in_flight.addr, in_flight.value,
                      in_flight.index, in_flight.token};
          s_tuser <= in_flight.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data = m_tdata[DATA_W-1:0];
        got.count = m_tdata[DATA_W +: COUNT_W];
        got.last = m_tlast;
        got.status = m_tuser;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result data=%h count=%0d last=%0d status=%0d",
                   $time, got.data, got.count, got.last, got.status);
          n_fail++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected data=%h count=%0d last=%0d status=%0d,",
                      " got data=%h count=%0d last=%0d status=%0d"},
                     $time, want.data, want.count, want.last, want.status,
                     got.data, got.count, got.last, got.status);
            n_fail++;
          end
        end
        n_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && n_done >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (n_done >= RECV_CALM_LO && n_done < RECV_CALM_HI) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_dictionary_token_expander_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned top, tok, first, stop, span, pick, n_rand;

    // dense block at the top of the store, long enough for truncation
    top = DICT_BYTES - PRELOAD;
    for (int unsigned i = 0; i < PRELOAD; i++) queue_byte(top + i, $urandom_range(0, 255));

    queue_entry(0, top, DICT_BYTES);                  // truncated
    queue_expand(0);
    queue_entry(2, top + 4, top + 4 + MAX_ENTRY_BYTES); // exactly the maximum
    queue_expand(2);
    queue_entry(6, top + 100, top + 100);             // empty
    queue_expand(6);
    queue_entry(10, top + 50, top + 49);              // end below start
    queue_expand(10);
    queue_entry(12, DICT_BYTES, 0);
    queue_expand(12);
    queue_entry(18, DICT_BYTES - 9, DICT_BYTES);      // full beat plus one byte
    queue_expand(18);
    queue_entry(TOKEN_COUNT - 1, DICT_BYTES - 7, DICT_BYTES);
    queue_expand(TOKEN_COUNT - 1);
    queue_byte(0, 8'hFF);
    queue_entry(20, 0, 1);
    queue_expand(20);
    queue_nop();

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        tok = $urandom_range(0, TOKEN_COUNT - 1);
        span = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 30);
        first = $urandom_range(0, DICT_BYTES - span);
        for (int unsigned i = 0; i < span; i++) queue_byte(first + i, $urandom_range(0, 255));
        queue_entry(tok, first, first + span);
        queue_expand(tok);
        n_rand += span + 3;
      end else if (pick < 72) begin
        tok = known_tokens[$urandom_range(0, known_tokens.size() - 1)];
        if (entry_readable(tok)) begin
          queue_expand(tok);
          n_rand++;
        end
      end else if (pick < 80) begin
        tok = $urandom_range(0, TOKEN_COUNT - 1);
        first = $urandom_range(1, DICT_BYTES);
        queue_entry(tok, first, $urandom_range(0, first - 1));
        queue_expand(tok);
        n_rand += 3;
      end else if (pick < 88) begin
        queue_byte($urandom_range(0, DICT_BYTES - 1), $urandom_range(0, 255));
        n_rand++;
      end else if (pick < 95) begin
        queue_offset($urandom_range(0, TOKEN_COUNT), $urandom_range(0, DICT_BYTES));
        n_rand++;
      end else begin
        queue_nop();
        n_rand++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_dictionary_token_expander_top OK");
    end else begin
      $display("tb_dictionary_token_expander_top NOT OK");
    end
    $finish;
  end

endmodule
